@@ sv/utf8vc_pkg.sv @@
// Shared types, state codes and helpers for the UTF-8 validator and code point counter.
package utf8vc_pkg;

   // Decoder state between two bytes: continuations still owed and the range
   // the next continuation byte must fall in.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_P1,
      ST_P2_ANY,
      ST_P2_A0BF,
      ST_P2_809F,
      ST_P3_ANY,
      ST_P3_90BF,
      ST_P3_808F
   } state_type;

   localparam int NSTATES = 8;
   localparam int CNT_W   = 5;

   localparam logic [7:0] ASCII_END  = 8'h80;
   localparam logic [7:0] LEAD2_MIN  = 8'hC2;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD_END   = 8'hF5;
   localparam logic [7:0] LEAD_E0    = 8'hE0;
   localparam logic [7:0] LEAD_ED    = 8'hED;
   localparam logic [7:0] LEAD_F0    = 8'hF0;
   localparam logic [7:0] LEAD_F4    = 8'hF4;

   // What a run of bytes does when entered in one given state.
   typedef struct packed {
      state_type         next;
      logic              err;
      logic [CNT_W-1:0]  cnt;
   } entry_type;

   // Transition map: one entry for every possible entry state.
   typedef entry_type [NSTATES-1:0] map_type;

   typedef struct packed {
      logic [63:0] bytes_low;
      logic [63:0] bytes_high;
      logic [4:0]  byte_count;
      logic        last_chunk;
   } req_type;

   typedef struct packed {
      logic [31:0] codepoint_count;
      logic        invalid;
   } rsp_type;

   function automatic map_type identity_map();
      map_type m;
      for (int s = 0; s < NSTATES; s++) begin
         m[s].next = state_type'(3'(s));
         m[s].err  = 1'b0;
         m[s].cnt  = '0;
      end
      return m;
   endfunction

endpackage

@@ sv/utf8vc_lane.sv @@
// One byte lane: transition map of a single byte for all entry states, registered.
module utf8vc_lane (
   input  logic                  clock,
   input  logic                  load,
   input  logic                  lane_on,
   input  logic                  surr_allow,
   input  logic [7:0]            byte_in,
   output utf8vc_pkg::map_type   map_ff
);

   utf8vc_pkg::map_type map_in;

   function automatic utf8vc_pkg::entry_type step_byte(input utf8vc_pkg::state_type s,
                                                       input logic [7:0] b,
                                                       input logic allow);
      utf8vc_pkg::entry_type e;
      logic cont_hit;
      e.next   = utf8vc_pkg::ST_IDLE;
      e.err    = 1'b0;
      e.cnt    = '0;
      case (s)
         utf8vc_pkg::ST_P1,
         utf8vc_pkg::ST_P2_ANY,
         utf8vc_pkg::ST_P3_ANY:  cont_hit = b inside {[8'h80:8'hBF]};
         utf8vc_pkg::ST_P2_A0BF: cont_hit = b inside {[8'hA0:8'hBF]};
         utf8vc_pkg::ST_P2_809F: cont_hit = b inside {[8'h80:8'h9F]};
         utf8vc_pkg::ST_P3_90BF: cont_hit = b inside {[8'h90:8'hBF]};
         utf8vc_pkg::ST_P3_808F: cont_hit = b inside {[8'h80:8'h8F]};
         default:                cont_hit = 1'b0;
      endcase
      if (cont_hit) begin
         case (s)
            utf8vc_pkg::ST_P1:      e.next = utf8vc_pkg::ST_IDLE;
            utf8vc_pkg::ST_P2_ANY,
            utf8vc_pkg::ST_P2_A0BF,
            utf8vc_pkg::ST_P2_809F: e.next = utf8vc_pkg::ST_P1;
            default:                e.next = utf8vc_pkg::ST_P2_ANY;
         endcase
      end else begin
         // A broken sequence is dropped and the byte is judged again as a lead.
         e.err = (s != utf8vc_pkg::ST_IDLE);
         if (b < utf8vc_pkg::ASCII_END) begin
            e.cnt = utf8vc_pkg::CNT_W'(1);
         end else if (b < utf8vc_pkg::LEAD2_MIN) begin
            e.err = 1'b1;
         end else if (b < utf8vc_pkg::LEAD3_MIN) begin
            e.cnt  = utf8vc_pkg::CNT_W'(1);
            e.next = utf8vc_pkg::ST_P1;
         end else if (b < utf8vc_pkg::LEAD4_MIN) begin
            e.cnt = utf8vc_pkg::CNT_W'(1);
            if (b == utf8vc_pkg::LEAD_E0) begin
               e.next = utf8vc_pkg::ST_P2_A0BF;
            end else if (b == utf8vc_pkg::LEAD_ED && !allow) begin
               e.next = utf8vc_pkg::ST_P2_809F;
            end else begin
               e.next = utf8vc_pkg::ST_P2_ANY;
            end
         end else if (b < utf8vc_pkg::LEAD_END) begin
            e.cnt = utf8vc_pkg::CNT_W'(1);
            if (b == utf8vc_pkg::LEAD_F0) begin
               e.next = utf8vc_pkg::ST_P3_90BF;
            end else if (b == utf8vc_pkg::LEAD_F4) begin
               e.next = utf8vc_pkg::ST_P3_808F;
            end else begin
               e.next = utf8vc_pkg::ST_P3_ANY;
            end
         end else begin
            e.err = 1'b1;
         end
      end
      return e;
   endfunction

   always_comb begin
      if (lane_on) begin
         for (int s = 0; s < utf8vc_pkg::NSTATES; s++) begin
            map_in[s] = step_byte(utf8vc_pkg::state_type'(3'(s)), byte_in, surr_allow);
         end
      end else begin
         map_in = utf8vc_pkg::identity_map();
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         map_ff <= map_in;
      end
   end

endmodule

@@ sv/utf8vc_merge.sv @@
// One level of the merge tree: composes neighboring transition maps pairwise.
module utf8vc_merge #(
   parameter int PAD   = 16,
   parameter int NODES = 8
) (
   input  logic                 clock,
   input  logic                 load,
   input  utf8vc_pkg::map_type  in_map  [PAD],
   output utf8vc_pkg::map_type  out_map [PAD]
);

   utf8vc_pkg::map_type comp_in [NODES];
   utf8vc_pkg::map_type comp_ff [NODES];

   // The lower-indexed map covers the earlier bytes and is applied first.
   always_comb begin
      for (int n = 0; n < NODES; n++) begin
         for (int s = 0; s < utf8vc_pkg::NSTATES; s++) begin
            comp_in[n][s].next = in_map[2*n+1][in_map[2*n][s].next].next;
            comp_in[n][s].err  = in_map[2*n][s].err | in_map[2*n+1][in_map[2*n][s].next].err;
            comp_in[n][s].cnt  = in_map[2*n][s].cnt + in_map[2*n+1][in_map[2*n][s].next].cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         comp_ff <= comp_in;
      end
   end

   for (genvar gn = 0; gn < PAD; gn++) begin : g_out
      if (gn < NODES) begin : g_used
         assign out_map[gn] = comp_ff[gn];
      end else begin : g_pad
         assign out_map[gn] = utf8vc_pkg::identity_map();
      end
   end

endmodule

@@ sv/utf8vc_accum.sv @@
// Final stage: applies the chunk map to the carried state, counts, and holds the result word.
module utf8vc_accum #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tail_valid,
   input  logic                 tail_last,
   input  utf8vc_pkg::map_type  tail_map,
   output logic                 tail_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output utf8vc_pkg::rsp_type  rsp_data
);

   utf8vc_pkg::state_type   state_ff, state_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   utf8vc_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   utf8vc_pkg::entry_type   entry;
   logic [COUNT_WIDTH:0]    sum;
   logic [COUNT_WIDTH-1:0]  count_sat;
   logic [63:0]             count_wide;
   logic [31:0]             count_out;
   logic                    err_all;
   logic                    bad;
   logic                    take;

   assign tail_ready = !(tail_last && rsp_valid_ff && rsp_stall);
   assign take       = tail_valid && tail_ready;

   always_comb begin
      entry      = tail_map[state_ff];
      sum        = {1'b0, count_ff} + (COUNT_WIDTH+1)'(entry.cnt);
      count_sat  = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
      count_wide = 64'(count_sat);
      count_out  = (|count_wide[63:32]) ? 32'hFFFF_FFFF : count_wide[31:0];
      err_all    = err_ff | entry.err;
      // A sequence still open after the final byte makes the string invalid.
      bad        = err_all || (entry.next != utf8vc_pkg::ST_IDLE);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         if (tail_last) begin
            state_in                    = utf8vc_pkg::ST_IDLE;
            count_in                    = '0;
            err_in                      = 1'b0;
            rsp_valid_in                = 1'b1;
            rsp_data_in.codepoint_count = bad ? 32'd0 : count_out;
            rsp_data_in.invalid         = bad;
         end else begin
            state_in = entry.next;
            count_in = count_sat;
            err_in   = err_all;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= utf8vc_pkg::ST_IDLE;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      take && tail_last |=> state_ff == utf8vc_pkg::ST_IDLE && count_ff == '0 && !err_ff)
      else $error("stream state not cleared after the last word");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.invalid |-> rsp_data_ff.codepoint_count == 32'd0)
      else $error("invalid result carries a nonzero count");

   a_block_reason: assert property (@(posedge clock) disable iff (reset)
      !tail_ready |-> rsp_valid_ff && rsp_stall)
      else $error("final stage blocked without a waiting result");

endmodule

@@ sv/utf8_validate_and_count.sv @@
// Top level: UTF-8 validator and code point counter over chunks of up to 16 bytes.
// Pipeline: the accepting edge loads the lane registers; a word then passes through the
// register of each merge-tree level and then the result stage. Throughput: one chunk per cycle,
// except while req_stall is held because a finished result waits under rsp_stall; the carried
// decoder state closes its loop through a single 8-way map lookup. Reset is synchronous and
// active high; it clears the pipeline, the stream state and the surrogate setting.
module utf8_validate_and_count #(
   parameter int LANES       = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  utf8vc_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output utf8vc_pkg::rsp_type  rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data
);

   localparam int LEVELS = $clog2(LANES);
   localparam int PAD    = 1 << LEVELS;

   logic                 allow_ff, allow_in;
   logic [LEVELS:0]      valid_ff, valid_in;
   logic [LEVELS:0]      last_ff, last_in;
   logic [LEVELS+1:0]    stage_ready;
   logic                 tail_ready;
   logic [4:0]           n_sat;
   logic [127:0]         chunk_bytes;
   utf8vc_pkg::map_type  tree [LEVELS+1][PAD];

   assign csr_ready   = 1'b1;
   assign allow_in    = (csr_valid && csr_ready) ? csr_data : allow_ff;
   assign chunk_bytes = {req_data.bytes_high, req_data.bytes_low};
   assign n_sat       = (req_data.byte_count > 5'(LANES)) ? 5'(LANES) : req_data.byte_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff <= 1'b0;
      end else begin
         allow_ff <= allow_in;
      end
   end

   // A stage may load when it is empty or its word moves on this cycle.
   always_comb begin
      stage_ready[LEVELS+1] = tail_ready;
      for (int k = LEVELS; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   assign req_stall = !stage_ready[0];

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      if (stage_ready[0]) begin
         valid_in[0] = req_valid;
         last_in[0]  = req_data.last_chunk;
      end
      for (int k = 1; k <= LEVELS; k++) begin
         if (stage_ready[k]) begin
            valid_in[k] = valid_ff[k-1];
            last_in[k]  = last_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   for (genvar gi = 0; gi < PAD; gi++) begin : g_lane
      utf8vc_lane u_lane (
         .clock      (clock),
         .load       (stage_ready[0]),
         .lane_on    (5'(gi) < n_sat),
         .surr_allow (allow_ff),
         .byte_in    (chunk_bytes[8*gi +: 8]),
         .map_ff     (tree[0][gi])
      );
   end

   for (genvar gl = 1; gl <= LEVELS; gl++) begin : g_level
      utf8vc_merge #(
         .PAD   (PAD),
         .NODES (PAD >> gl)
      ) u_merge (
         .clock   (clock),
         .load    (stage_ready[gl]),
         .in_map  (tree[gl-1]),
         .out_map (tree[gl])
      );
   end

   utf8vc_accum #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .tail_valid (valid_ff[LEVELS]),
      .tail_last  (last_ff[LEVELS]),
      .tail_map   (tree[LEVELS][0]),
      .tail_ready (tail_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff[0])
      else $error("input stalled while the lane stage is empty");

endmodule
